// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file crt_checker.
// Each macro expands to one labeled concurrent assertion on a clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CRT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define CRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/crt_pkg.sv -----
// Shared types and codes for the controller resync tracker.
// No dependencies; used by crt_engine, controller_resync_tracker and the testbench.
`default_nettype none

package crt_pkg;

  // request types
  localparam logic [2:0] REQ_TICK          = 3'd0;
  localparam logic [2:0] REQ_FEATURES_REPLY = 3'd1;
  localparam logic [2:0] REQ_FEATURES_REQ  = 3'd2;
  localparam logic [2:0] REQ_FLOW_MOD      = 3'd3;
  localparam logic [2:0] REQ_GROUP_MOD     = 3'd4;
  localparam logic [2:0] REQ_RESYNC        = 3'd5;

  // flow/group mod commands
  localparam logic [2:0] MOD_ADD           = 3'd0;
  localparam logic [2:0] MOD_MODIFY        = 3'd1;
  localparam logic [2:0] MOD_MODIFY_STRICT = 3'd2;

  // resync commands
  localparam logic [1:0] RESYNC_START  = 2'd0;
  localparam logic [1:0] RESYNC_ABORT  = 2'd1;
  localparam logic [1:0] RESYNC_FINISH = 2'd2;

  // response codes
  localparam logic [1:0] RSP_INIT_ACK   = 2'd0;
  localparam logic [1:0] RSP_INIT_EMPTY = 2'd1;
  localparam logic [1:0] RSP_ABORT_ACK  = 2'd2;
  localparam logic [1:0] RSP_FINISH_OK  = 2'd3;

  // link states (code three behaves as disconnected)
  localparam logic [1:0] LINK_DISCONNECTED = 2'd0;
  localparam logic [1:0] LINK_CONNECTING   = 2'd1;
  localparam logic [1:0] LINK_CONNECTED    = 2'd2;

  localparam logic [15:0] CONTROLLER_PORT_RESET = 16'd6633;
  localparam logic [31:0] NEVER_STAMP           = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  mod_command;
    logic [1:0]  resync_command;
    logic [31:0] transaction_id;
    logic [31:0] now_seconds;
    logic [31:0] controller_ip;
    logic        remote_link_up;
  } event_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  response_code;
    logic [31:0] reply_transaction_id;
    logic [63:0] reply_controller_id;
    logic [31:0] first_connect_time;
    logic [31:0] lost_elapsed;
  } reply_t;

endpackage

`default_nettype wire

// ----- hw/rtl/crt_engine.sv -----
// Connection/resync state registers and per-event update and reply logic.
// Depends on crt_pkg.
`default_nettype none

module crt_engine (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire crt_pkg::event_t ev,
  input  wire logic [15:0]     ctrl_port,
  output crt_pkg::reply_t      reply
);

  logic [1:0]  link_state,  link_state_next;
  logic        resync_active, resync_active_next;
  logic        fwd_modified, fwd_modified_next;
  logic [31:0] first_stamp, first_stamp_next;
  logic        first_seen,  first_seen_next;
  logic [63:0] cur_id,      cur_id_next;
  logic [63:0] prev_id,     prev_id_next;
  logic [31:0] lost_stamp,  lost_stamp_next;
  logic        lost_seen,   lost_seen_next;

  always_comb begin
    logic disc;
    disc = 1'b0;
    link_state_next    = link_state;
    resync_active_next = resync_active;
    fwd_modified_next  = fwd_modified;
    first_stamp_next   = first_stamp;
    first_seen_next    = first_seen;
    cur_id_next        = cur_id;
    prev_id_next       = prev_id;
    lost_stamp_next    = lost_stamp;
    lost_seen_next     = lost_seen;

    reply.valid                = 1'b0;
    reply.response_code        = crt_pkg::RSP_INIT_ACK;
    reply.reply_transaction_id = ev.transaction_id;
    reply.first_connect_time   = first_stamp;
    reply.lost_elapsed         = lost_seen ? (ev.now_seconds - lost_stamp) : '1;

    unique case (ev.req_type)
      crt_pkg::REQ_TICK: begin
        if (!ev.remote_link_up) begin
          disc = 1'b1;
          link_state_next = crt_pkg::LINK_DISCONNECTED;
        end
      end
      crt_pkg::REQ_FEATURES_REPLY: begin
        if (link_state == crt_pkg::LINK_CONNECTING) begin
          if (!first_seen) begin
            first_stamp_next = ev.now_seconds;
            first_seen_next  = 1'b1;
          end
          cur_id_next     = {ev.controller_ip, 16'd0, ctrl_port};
          link_state_next = crt_pkg::LINK_CONNECTED;
        end
        resync_active_next = 1'b0;
      end
      crt_pkg::REQ_FEATURES_REQ: begin
        disc = 1'b1;
        link_state_next = crt_pkg::LINK_CONNECTING;
      end
      crt_pkg::REQ_FLOW_MOD: begin
        if (ev.mod_command == crt_pkg::MOD_ADD || ev.mod_command == crt_pkg::MOD_MODIFY ||
            ev.mod_command == crt_pkg::MOD_MODIFY_STRICT) begin
          fwd_modified_next = 1'b1;
        end
      end
      crt_pkg::REQ_GROUP_MOD: begin
        if (ev.mod_command == crt_pkg::MOD_ADD || ev.mod_command == crt_pkg::MOD_MODIFY) begin
          fwd_modified_next = 1'b1;
        end
      end
      crt_pkg::REQ_RESYNC: begin
        unique case (ev.resync_command)
          crt_pkg::RESYNC_START: begin
            if (!resync_active) begin
              reply.valid = 1'b1;
              if (fwd_modified) begin
                reply.response_code = crt_pkg::RSP_INIT_ACK;
                resync_active_next  = 1'b1;
              end else begin
                reply.response_code = crt_pkg::RSP_INIT_EMPTY;
              end
            end
          end
          crt_pkg::RESYNC_ABORT: begin
            if (resync_active) begin
              reply.valid         = 1'b1;
              reply.response_code = crt_pkg::RSP_ABORT_ACK;
              resync_active_next  = 1'b0;
            end
          end
          crt_pkg::RESYNC_FINISH: begin
            if (resync_active) begin
              reply.valid         = 1'b1;
              reply.response_code = crt_pkg::RSP_FINISH_OK;
              resync_active_next  = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // leaving the connected state records the loss
    if (disc && link_state == crt_pkg::LINK_CONNECTED) begin
      prev_id_next    = cur_id;
      lost_stamp_next = ev.now_seconds;
      lost_seen_next  = 1'b1;
    end

    reply.reply_controller_id =
      (reply.response_code == crt_pkg::RSP_INIT_EMPTY) ? cur_id : prev_id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_state    <= crt_pkg::LINK_DISCONNECTED;
      resync_active <= 1'b0;
      fwd_modified  <= 1'b0;
      first_stamp   <= crt_pkg::NEVER_STAMP;
      first_seen    <= 1'b0;
      cur_id        <= '1;
      prev_id       <= '1;
      lost_stamp    <= '0;
      lost_seen     <= 1'b0;
    end else if (fire) begin
      link_state    <= link_state_next;
      resync_active <= resync_active_next;
      fwd_modified  <= fwd_modified_next;
      first_stamp   <= first_stamp_next;
      first_seen    <= first_seen_next;
      cur_id        <= cur_id_next;
      prev_id       <= prev_id_next;
      lost_stamp    <= lost_stamp_next;
      lost_seen     <= lost_seen_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/controller_resync_tracker.sv -----
// A request accepted is first held in the input register; its reply (if any) is then
// registered in the reply register once that register is free or being drained.
// Throughput: one request per cycle while no untaken reply stalls the update pass.
// in_ready drops only while a buffered request waits behind an untaken reply.
// Reset (rst, synchronous, active high) clears the connection state, flags,
// controller ids and stamps to their defaults and sets the port register ctrl_port to 6633.
`default_nettype none

module controller_resync_tracker (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [2:0]  mod_command,
  input  wire logic [1:0]  resync_command,
  input  wire logic [31:0] transaction_id,
  input  wire logic [31:0] now_seconds,
  input  wire logic [31:0] controller_ip,
  input  wire logic        remote_link_up,
  // reply channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       response_code,
  output logic [31:0]      reply_transaction_id,
  output logic [63:0]      reply_controller_id,
  output logic [31:0]      first_connect_time,
  output logic [31:0]      lost_elapsed,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] controller_port
);

  // Input register: holds one request for the update pass.
  crt_pkg::event_t ev;
  logic            ev_valid;
  // Config register: port placed in low bits of generated controller ids.
  logic [15:0]     ctrl_port;
  crt_pkg::reply_t reply;
  logic            advance;   // reply register is free or being drained, so the update pass may run
  logic            fire;

  // The pass may run whenever the reply register is free or being drained,
  // even if this request produces no reply.
  assign advance   = !out_valid || out_ready;
  assign fire      = ev_valid && advance;
  assign in_ready  = !ev_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid  <= 1'b0;
      ctrl_port <= crt_pkg::CONTROLLER_PORT_RESET;
    end else begin
      if (in_ready) ev_valid <= in_valid;
      if (cfg_valid) ctrl_port <= controller_port;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev.req_type       <= req_type;
      ev.mod_command    <= mod_command;
      ev.resync_command <= resync_command;
      ev.transaction_id <= transaction_id;
      ev.now_seconds    <= now_seconds;
      ev.controller_ip  <= controller_ip;
      ev.remote_link_up <= remote_link_up;
    end
  end

  // State update and reply build for the buffered request.
  crt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .ev        (ev),
    .ctrl_port (ctrl_port),
    .reply     (reply)
  );

  // Reply register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && reply.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && reply.valid) begin
      response_code        <= reply.response_code;
      reply_transaction_id <= reply.reply_transaction_id;
      reply_controller_id  <= reply.reply_controller_id;
      first_connect_time   <= reply.first_connect_time;
      lost_elapsed         <= reply.lost_elapsed;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/crt_checker.sv -----
// Port-level checks for controller_resync_tracker, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module crt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  response_code,
  input wire logic [31:0] reply_transaction_id,
  input wire logic [63:0] reply_controller_id,
  input wire logic [31:0] first_connect_time,
  input wire logic [31:0] lost_elapsed
);

  logic [161:0] reply_bits;

  assign reply_bits = {response_code, reply_transaction_id, reply_controller_id,
                       first_connect_time, lost_elapsed};

  // a stalled reply holds
  `CRT_ASSERT_NEXT(a_reply_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(reply_bits))

  // backpressure only comes from an untaken reply
  `CRT_ASSERT_IMPL(a_ready_cause, clk, rst, !in_ready, out_valid && !out_ready)

  // no reply right after reset
  `CRT_ASSERT_IMPL(a_reset_empty, clk, rst, $past(rst), !out_valid)

endmodule

bind controller_resync_tracker crt_checker u_crt_checker (.*);

`default_nettype wire

// ----- dv/controller_resync_tracker_tb.sv -----
// Self-checking testbench for controller_resync_tracker: drives channel events and
// port writes, predicts each resync reply in a ledger class and compares field by field.
// Depends on crt_pkg (codes, event_t) and the controller_resync_tracker RTL.
module controller_resync_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // codes the package leaves out; the block must ignore them
  localparam logic [2:0] REQ_OTHER         = 3'd6;
  localparam logic [2:0] REQ_UNKNOWN       = 3'd7;
  localparam logic [2:0] MOD_DELETE        = 3'd3;
  localparam logic [2:0] MOD_DELETE_STRICT = 3'd4;
  localparam logic [2:0] MOD_BOGUS         = 3'd7;
  localparam logic [1:0] RESYNC_IGNORED    = 2'd3;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;    // covers the input and reply registers behind a request
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_ITEMS   = 120;
  localparam int PHASES        = 5;

  typedef struct {
    logic [1:0]  code;
    logic [31:0] xid;
    logic [63:0] cid;
    logic [31:0] first;
    logic [31:0] lost;
  } reply_item_t;

  // Mirror of the connection tracker plus the queue of replies it owes.
  class reply_ledger;
    logic [15:0] port;
    logic [1:0]  link;
    bit          active, modified, first_seen, lost_seen;
    logic [31:0] first_stamp, lost_stamp;
    logic [63:0] cur_id, prev_id;
    reply_item_t pending_replies[$];
    int          errors;
    int          checked;

    function new();
      port        = crt_pkg::CONTROLLER_PORT_RESET;
      link        = crt_pkg::LINK_DISCONNECTED;
      active      = 0;
      modified    = 0;
      first_seen  = 0;
      lost_seen   = 0;
      first_stamp = crt_pkg::NEVER_STAMP;
      lost_stamp  = '0;
      cur_id      = '1;
      prev_id     = '1;
      errors      = 0;
      checked     = 0;
    endfunction

    function void set_port(logic [15:0] value);
      port = value;
    endfunction

    function void drop_link(logic [31:0] now);
      if (link == crt_pkg::LINK_CONNECTED) begin
        prev_id    = cur_id;
        lost_stamp = now;
        lost_seen  = 1;
      end
      link = crt_pkg::LINK_DISCONNECTED;
    endfunction

    function void queue_reply(logic [1:0] code, logic [31:0] xid, logic [31:0] now);
      reply_item_t r;
      r.code  = code;
      r.xid   = xid;
      r.cid   = (code == crt_pkg::RSP_INIT_EMPTY) ? cur_id : prev_id;
      r.first = first_stamp;
      r.lost  = lost_seen ? now - lost_stamp : 32'hFFFF_FFFF;
      pending_replies.push_back(r);
    endfunction

    function void note_request(crt_pkg::event_t ev);
      case (ev.req_type)
        crt_pkg::REQ_TICK: if (!ev.remote_link_up) drop_link(ev.now_seconds);
        crt_pkg::REQ_FEATURES_REPLY: begin
          if (link == crt_pkg::LINK_CONNECTING) begin
            if (!first_seen) begin
              first_stamp = ev.now_seconds;
              first_seen  = 1;
            end
            cur_id = {ev.controller_ip, 16'h0000, port};
            link   = crt_pkg::LINK_CONNECTED;
          end
          active = 0;
        end
        crt_pkg::REQ_FEATURES_REQ: begin
          drop_link(ev.now_seconds);
          link = crt_pkg::LINK_CONNECTING;
        end
        crt_pkg::REQ_FLOW_MOD:
          if (ev.mod_command <= crt_pkg::MOD_MODIFY_STRICT) modified = 1;
        crt_pkg::REQ_GROUP_MOD:
          if (ev.mod_command <= crt_pkg::MOD_MODIFY) modified = 1;
        crt_pkg::REQ_RESYNC: begin
          case (ev.resync_command)
            crt_pkg::RESYNC_START: begin
              if (!active) begin
                if (modified) begin
                  queue_reply(crt_pkg::RSP_INIT_ACK, ev.transaction_id, ev.now_seconds);
                  active = 1;
                end else begin
                  queue_reply(crt_pkg::RSP_INIT_EMPTY, ev.transaction_id, ev.now_seconds);
                end
              end
            end
            crt_pkg::RESYNC_ABORT, crt_pkg::RESYNC_FINISH: begin
              if (active) begin
                queue_reply((ev.resync_command == crt_pkg::RESYNC_ABORT) ?
                              crt_pkg::RSP_ABORT_ACK : crt_pkg::RSP_FINISH_OK,
                            ev.transaction_id, ev.now_seconds);
                active = 0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got %h want %h (reply %0d)", what, got, want, checked);
    endtask

    task check_reply(reply_item_t got);
      reply_item_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with none pending", 64'(got.xid), 64'd0);
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      if (got.code !== want.code)
        report_mismatch("response_code", 64'(got.code), 64'(want.code));
      if (got.xid !== want.xid)
        report_mismatch("reply_transaction_id", 64'(got.xid), 64'(want.xid));
      if (got.cid !== want.cid)
        report_mismatch("reply_controller_id", got.cid, want.cid);
      if (got.first !== want.first)
        report_mismatch("first_connect_time", 64'(got.first), 64'(want.first));
      if (got.lost !== want.lost)
        report_mismatch("lost_elapsed", 64'(got.lost), 64'(want.lost));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  req_type;
  logic [2:0]  mod_command;
  logic [1:0]  resync_command;
  logic [31:0] transaction_id;
  logic [31:0] now_seconds;
  logic [31:0] controller_ip;
  logic        remote_link_up;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  response_code;
  logic [31:0] reply_transaction_id;
  logic [63:0] reply_controller_id;
  logic [31:0] first_connect_time;
  logic [31:0] lost_elapsed;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] controller_port;

  reply_ledger     ledger = new();
  int              send_idle_pct;
  int              recv_stall_pct;
  int              items_sent;
  int              cycle_count;
  logic [31:0]     now_base;
  crt_pkg::event_t seen_request;
  reply_item_t     seen_reply;

  controller_resync_tracker uut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .req_type             (req_type),
    .mod_command          (mod_command),
    .resync_command       (resync_command),
    .transaction_id       (transaction_id),
    .now_seconds          (now_seconds),
    .controller_ip        (controller_ip),
    .remote_link_up       (remote_link_up),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .response_code        (response_code),
    .reply_transaction_id (reply_transaction_id),
    .reply_controller_id  (reply_controller_id),
    .first_connect_time   (first_connect_time),
    .lost_elapsed         (lost_elapsed),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .controller_port      (controller_port)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang or a lost reply ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: all three handshakes sampled at the edge, pre-update values.
  // Requests are noted before replies are checked; a reply never shares
  // an edge with its own request anyway.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) ledger.set_port(controller_port);
      if (in_valid && in_ready) begin
        seen_request = {req_type, mod_command, resync_command, transaction_id,
                        now_seconds, controller_ip, remote_link_up};
        ledger.note_request(seen_request);
      end
      if (out_valid && out_ready) begin
        seen_reply.code  = response_code;
        seen_reply.xid   = reply_transaction_id;
        seen_reply.cid   = reply_controller_id;
        seen_reply.first = first_connect_time;
        seen_reply.lost  = lost_elapsed;
        ledger.check_reply(seen_reply);
      end
    end
  end

  // Mostly advancing time; now and then a wild jump so every bit toggles.
  function automatic logic [31:0] next_now();
    if ($urandom_range(9) == 0) return $urandom;
    now_base += $urandom_range(5000);
    return now_base;
  endfunction

  function automatic crt_pkg::event_t build(logic [2:0] t, logic [2:0] m, logic [1:0] c,
                                            logic [31:0] now, logic [31:0] ip, logic up);
    crt_pkg::event_t ev;
    ev.req_type       = t;
    ev.mod_command    = m;
    ev.resync_command = c;
    ev.transaction_id = $urandom;
    ev.now_seconds    = now;
    ev.controller_ip  = ip;
    ev.remote_link_up = up;
    return ev;
  endfunction

  function automatic crt_pkg::event_t random_request();
    return build(3'($urandom_range(7)), 3'($urandom_range(7)), 2'($urandom_range(3)),
                 next_now(), $urandom, 1'($urandom_range(1)));
  endfunction

  // Valid stays high from one request to the next when no gap is drawn.
  task automatic send(crt_pkg::event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {req_type, mod_command, resync_command, transaction_id,
     now_seconds, controller_ip, remote_link_up} <= ev;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Shorthand for a request whose other fields are random.
  task automatic send_op(logic [2:0] t, logic [2:0] m, logic [1:0] c);
    send(build(t, m, c, next_now(), $urandom, 1'($urandom_range(1))));
  endtask

  // Idle means: no request offered, every reply drained, pipeline settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_port(logic [15:0] value);
    wait_idle();
    cfg_valid       <= 1'b1;
    controller_port <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A controller session: connect, touch the tables, resync, then wind down
  // one of several ways. Random content throughout.
  task automatic run_session();
    int n;
    send_op(crt_pkg::REQ_FEATURES_REQ, 3'($urandom_range(7)), 2'($urandom_range(3)));
    if ($urandom_range(9) != 0)
      send_op(crt_pkg::REQ_FEATURES_REPLY, 3'($urandom_range(7)), 2'($urandom_range(3)));
    n = $urandom_range(3);
    repeat (n) send_op($urandom_range(1) ? crt_pkg::REQ_FLOW_MOD : crt_pkg::REQ_GROUP_MOD,
                       ($urandom_range(7) == 0) ? MOD_BOGUS : 3'($urandom_range(4)),
                       2'($urandom_range(3)));
    send_op(crt_pkg::REQ_RESYNC, 3'($urandom_range(7)), crt_pkg::RESYNC_START);
    if ($urandom_range(3) == 0) send(random_request());
    case ($urandom_range(4))
      0: send_op(crt_pkg::REQ_RESYNC, 3'($urandom_range(7)), crt_pkg::RESYNC_ABORT);
      1: send_op(crt_pkg::REQ_RESYNC, 3'($urandom_range(7)), crt_pkg::RESYNC_FINISH);
      2: send_op(crt_pkg::REQ_FEATURES_REPLY, 3'($urandom_range(7)), 2'($urandom_range(3)));
      3: send_op(crt_pkg::REQ_RESYNC, 3'($urandom_range(7)), crt_pkg::RESYNC_START);
      default: ;
    endcase
    if ($urandom_range(1))
      send(build(crt_pkg::REQ_TICK, 3'($urandom_range(7)), 2'($urandom_range(3)),
                 next_now(), $urandom, 1'b0));
  endtask

  initial begin
    crt_pkg::event_t ev;
    logic [15:0]     port_plan [PHASES];
    int              target;

    rst             <= 1'b1;
    in_valid        <= 1'b0;
    req_type        <= '0;
    mod_command     <= '0;
    resync_command  <= '0;
    transaction_id  <= '0;
    now_seconds     <= '0;
    controller_ip   <= '0;
    remote_link_up  <= 1'b0;
    out_ready       <= 1'b0;
    cfg_valid       <= 1'b0;
    controller_port <= crt_pkg::CONTROLLER_PORT_RESET;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    items_sent      = 0;
    now_base        = $urandom;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, reset port value in force ----
    // fresh block: init answers empty with reset ids, never-connected and never-lost
    ev = build(crt_pkg::REQ_RESYNC, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START,
               32'd0, 32'd0, 1'b0);
    ev.transaction_id = 32'd0;
    send(ev);
    // abort/finish with no resync running, and the ignored command: silent
    send_op(crt_pkg::REQ_RESYNC, crt_pkg::MOD_ADD, crt_pkg::RESYNC_ABORT);
    send_op(crt_pkg::REQ_RESYNC, crt_pkg::MOD_ADD, crt_pkg::RESYNC_FINISH);
    send_op(crt_pkg::REQ_RESYNC, crt_pkg::MOD_ADD, RESYNC_IGNORED);
    // tick with link up does nothing; link down while already disconnected too
    send(build(crt_pkg::REQ_TICK, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START,
               next_now(), $urandom, 1'b1));
    send(build(crt_pkg::REQ_TICK, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START,
               next_now(), $urandom, 1'b0));
    // features reply without a pending features request: no connection
    send_op(crt_pkg::REQ_FEATURES_REPLY, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START);
    // connect with extreme ip and time zero as first-connection time
    send_op(crt_pkg::REQ_FEATURES_REQ, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START);
    send(build(crt_pkg::REQ_FEATURES_REPLY, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START,
               32'd0, 32'hFFFF_FFFF, 1'b0));
    ev = build(crt_pkg::REQ_RESYNC, MOD_BOGUS, crt_pkg::RESYNC_START,
               32'hFFFF_FFFF, 32'd0, 1'b1);
    ev.transaction_id = 32'hFFFF_FFFF;
    send(ev);
    // mods that must not mark forwarding as modified, and ignored types
    send_op(crt_pkg::REQ_FLOW_MOD, MOD_DELETE, crt_pkg::RESYNC_START);
    send_op(crt_pkg::REQ_FLOW_MOD, MOD_BOGUS, crt_pkg::RESYNC_START);
    send_op(crt_pkg::REQ_GROUP_MOD, crt_pkg::MOD_MODIFY_STRICT, crt_pkg::RESYNC_START);
    send_op(crt_pkg::REQ_GROUP_MOD, MOD_DELETE_STRICT, crt_pkg::RESYNC_START);
    send_op(REQ_OTHER, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START);
    send_op(REQ_UNKNOWN, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START);
    send_op(crt_pkg::REQ_RESYNC, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START);
    // now modify, drop the link near wrap and init: ack with wrapped elapsed
    send_op(crt_pkg::REQ_GROUP_MOD, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START);
    send(build(crt_pkg::REQ_TICK, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START,
               32'hFFFF_FFF0, $urandom, 1'b0));
    send(build(crt_pkg::REQ_RESYNC, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START,
               32'h0000_0010, $urandom, 1'b0));
    // init while resync is active is swallowed
    send_op(crt_pkg::REQ_RESYNC, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START);
    // a features reply in any state ends the resync
    send_op(crt_pkg::REQ_FEATURES_REPLY, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START);
    send_op(crt_pkg::REQ_RESYNC, crt_pkg::MOD_ADD, crt_pkg::RESYNC_ABORT);
    send_op(crt_pkg::REQ_RESYNC, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START);
    send_op(crt_pkg::REQ_RESYNC, crt_pkg::MOD_ADD, crt_pkg::RESYNC_FINISH);
    send_op(crt_pkg::REQ_RESYNC, crt_pkg::MOD_ADD, crt_pkg::RESYNC_START);
    send_op(crt_pkg::REQ_RESYNC, crt_pkg::MOD_ADD, crt_pkg::RESYNC_ABORT);

    // ---- random part: one port setting and one idle/stall mix per phase ----
    port_plan[0] = 16'h0000;
    port_plan[1] = 16'hFFFF;
    port_plan[2] = 16'($urandom);
    port_plan[3] = crt_pkg::CONTROLLER_PORT_RESET;
    port_plan[4] = 16'($urandom);
    for (int p = 0; p < PHASES; p++) begin
      write_port(port_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(99) < 60) run_session();
        else send(random_request());
      end
    end

    // drain: wait until nothing is owed, then stay quiet so a stray reply can show
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests across %0d port settings and four idle/stall mixes;",
             items_sent, PHASES + 1);
    $display("%0d resync replies checked, %0d mismatches.", ledger.checked, ledger.errors);
    if (ledger.errors == 0 && ledger.pending_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
